// ===== design/gclc_pkg.sv =====
// Shared types and codes for the group-commit log controller.
// Item payload structs, configuration struct and the action, status,
// command and pin codes. No dependencies.
`timescale 1ns / 1ps

package gclc_pkg;

   localparam int BLOCK_W   = 32;
   localparam int REGION_W  = 16;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      ACT_BEGIN = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_END   = 2'd2,
      ACT_SPARE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_RETRY     = 3'd1,
      STS_LOGGED    = 3'd2,
      STS_FULL      = 3'd3,
      STS_OUTSIDE   = 3'd4,
      STS_UNDERFLOW = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_COPY    = 3'd1,
      CMD_HEADER  = 3'd2,
      CMD_INSTALL = 3'd3,
      CMD_CLEAR   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      PIN_NONE  = 2'd0,
      PIN_PIN   = 2'd1,
      PIN_UNPIN = 2'd2
   } pin_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_REGION = 2'd1;

   typedef struct packed {
      logic [1:0]         action;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         command;
      logic [BLOCK_W-1:0] source_block;
      logic [BLOCK_W-1:0] dest_block;
      logic [COUNT_W-1:0] header_count;
      logic [1:0]         pin_change;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  log_start_block;
      logic [REGION_W-1:0] log_region_blocks;
   } cfg_type;

endpackage

// ===== design/gclc_log_mem.sv =====
// Table of logged home block numbers: one write port, one read port
// with registered read data. Depends on nothing.
`timescale 1ns / 1ps

module gclc_log_mem #(
   parameter int DEPTH  = 30,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gclc_engine.sv =====
// Sequencer of the log controller: admission, dedup scan and commit walk.
// Uses one comparator and one slot adder over the entry table; depends
// on gclc_pkg and drives the table in gclc_log_mem through its ports.
`timescale 1ns / 1ps

module gclc_engine #(
   parameter int LOG_ENTRIES = 30,
   parameter int OP_RESERVE  = 10,
   parameter int ADDR_W      = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gclc_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  gclc_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output gclc_pkg::rsp_type          rsp_data,
   output logic                       mem_wr_en,
   output logic [ADDR_W-1:0]          mem_wr_addr,
   output logic [gclc_pkg::BLOCK_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0]          mem_rd_addr,
   input  logic [gclc_pkg::BLOCK_W-1:0] mem_rd_data
);
   import gclc_pkg::*;

   localparam int NEED_W = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SINGLE,
      ST_COPY_RD,
      ST_COPY_OUT,
      ST_HEADER,
      ST_INST_RD,
      ST_INST_OUT,
      ST_CLEAR
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] open_ff, open_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               chk_ff, chk_in;
   logic               found_ff, found_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   status_type         sts_ff, sts_in;
   logic [BLOCK_W-1:0] dst_ff, dst_in;
   pin_type            pin_ff, pin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               emit;
   rsp_type            emit_data;
   logic [BLOCK_W-1:0] slot;
   logic [NEED_W-1:0]  need;
   logic               wr_full;
   logic               issue;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign slot     = cfg.log_start_block + BLOCK_W'(idx_ff) + BLOCK_W'(1);
   assign need     = NEED_W'(count_ff)
                   + (NEED_W'(open_ff) + NEED_W'(1)) * NEED_W'(OP_RESERVE);
   assign wr_full  = (count_ff >= COUNT_W'(LOG_ENTRIES))
                  || ((REGION_W'(count_ff) + REGION_W'(1)) >= cfg.log_region_blocks);
   assign issue    = idx_ff < count_ff;

   assign req_stall   = state_ff != ST_IDLE;
   assign mem_rd_addr = idx_ff[ADDR_W-1:0];
   assign mem_wr_addr = count_ff[ADDR_W-1:0];
   assign mem_wr_data = blk_ff;

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      chk_in       = chk_ff;
      found_in     = found_ff;
      blk_in       = blk_ff;
      sts_in       = sts_ff;
      dst_in       = dst_ff;
      pin_in       = pin_ff;
      mem_wr_en    = 1'b0;
      emit         = 1'b0;
      emit_data    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sts_in   = STS_OK;
               dst_in   = '0;
               pin_in   = PIN_NONE;
               state_in = ST_SINGLE;
               case (action_type'(req_data.action))
                  ACT_BEGIN: begin
                     if (need > NEED_W'(LOG_ENTRIES)) begin
                        sts_in = STS_RETRY;
                     end else begin
                        open_in = open_ff + COUNT_W'(1);
                     end
                  end
                  ACT_WRITE: begin
                     if (wr_full) begin
                        sts_in = STS_FULL;
                     end else if (open_ff == '0) begin
                        sts_in = STS_OUTSIDE;
                     end else begin
                        blk_in   = req_data.block_number;
                        idx_in   = '0;
                        chk_in   = 1'b0;
                        found_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_END: begin
                     if (open_ff == '0) begin
                        sts_in = STS_UNDERFLOW;
                     end else begin
                        open_in = open_ff - COUNT_W'(1);
                        // last operation closed: walk the commit if anything is logged
                        if (open_ff == COUNT_W'(1) && count_ff != '0) begin
                           idx_in   = '0;
                           state_in = ST_COPY_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // compare the entry read in the previous cycle, issue the next one
            if (chk_ff && mem_rd_data == blk_ff) begin
               found_in = 1'b1;
            end
            if (issue) begin
               idx_in = idx_ff + COUNT_W'(1);
            end
            chk_in = issue;
            if (!issue && !chk_ff) begin
               state_in = ST_SINGLE;
               if (found_ff) begin
                  sts_in = STS_LOGGED;
               end else begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + COUNT_W'(1);
                  sts_in    = STS_OK;
                  dst_in    = blk_ff;
                  pin_in    = PIN_PIN;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.status     = sts_ff;
               emit_data.command    = CMD_NONE;
               emit_data.dest_block = dst_ff;
               emit_data.pin_change = pin_ff;
               emit_data.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_OUT;
         end
         ST_COPY_OUT: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.status       = STS_OK;
               emit_data.command      = CMD_COPY;
               emit_data.source_block = mem_rd_data;
               emit_data.dest_block   = slot;
               emit_data.pin_change   = PIN_NONE;
               if (idx_ff + COUNT_W'(1) == count_ff) begin
                  idx_in   = '0;
                  state_in = ST_HEADER;
               end else begin
                  idx_in   = idx_ff + COUNT_W'(1);
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.status       = STS_OK;
               emit_data.command      = CMD_HEADER;
               emit_data.dest_block   = cfg.log_start_block;
               emit_data.header_count = count_ff;
               emit_data.pin_change   = PIN_NONE;
               state_in               = ST_INST_RD;
            end
         end
         ST_INST_RD: begin
            state_in = ST_INST_OUT;
         end
         ST_INST_OUT: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.status       = STS_OK;
               emit_data.command      = CMD_INSTALL;
               emit_data.source_block = slot;
               emit_data.dest_block   = mem_rd_data;
               emit_data.pin_change   = PIN_UNPIN;
               if (idx_ff + COUNT_W'(1) == count_ff) begin
                  state_in = ST_CLEAR;
               end else begin
                  idx_in   = idx_ff + COUNT_W'(1);
                  state_in = ST_INST_RD;
               end
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.status     = STS_OK;
               emit_data.command    = CMD_CLEAR;
               emit_data.dest_block = cfg.log_start_block;
               emit_data.pin_change = PIN_NONE;
               emit_data.last       = 1'b1;
               count_in             = '0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the result until taken
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      blk_ff      <= blk_in;
      sts_ff      <= sts_in;
      dst_ff      <= dst_in;
      pin_ff      <= pin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(LOG_ENTRIES))
      else $error("entry count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item produced no work");

   a_walk_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_OUT || state_ff == ST_HEADER || state_ff == ST_INST_OUT
       || state_ff == ST_CLEAR) |-> (open_ff == '0))
      else $error("commit walk with open operations");

   a_clear_resets_count: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.command == CMD_CLEAR) |=> (count_ff == '0))
      else $error("entry count kept after commit");

endmodule

// ===== design/group_commit_log_controller_core.sv =====
// Top level of the group-commit log controller: configuration registers,
// sequencer and entry table. Depends on gclc_pkg, gclc_engine, gclc_log_mem.
`timescale 1ns / 1ps

// Usage
//   req_*: one item per action (begin, log block write, end). An item is
//     taken when req_valid is high and req_stall low; req_stall stays high
//     while an item is being worked on, one item at a time.
//   rsp_*: result items; the final one of each input item has last set.
//     A result is taken when rsp_valid is high and rsp_stall low.
//   csr_*: register writes (0 log start block, 1 log region size), always
//     ready; write only while no item is in flight.
// Sequence
//   Begin, end without commit, refused writes: a single result item each.
//   Logged write: the dedup scan reads one table entry per cycle through
//     the single comparator, then the block is entered if it is new.
//   Commit of n entries: n copies, a header, n installs and a clear; each
//     copy or install result waits for its registered table read.
//   A stalled receiver holds the output register; the walk pauses there.
// Reset: open operations and entry count clear, registers take their
//   defaults (start block 2, region 32 blocks); table contents are stale.
module group_commit_log_controller_core #(
   parameter int LOG_ENTRIES = 30,
   parameter int OP_RESERVE  = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gclc_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gclc_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gclc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gclc_pkg::BLOCK_W-1:0]   csr_data
);
   import gclc_pkg::*;

   localparam int ADDR_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

   logic [BLOCK_W-1:0]  start_ff, start_in;
   logic [REGION_W-1:0] region_ff, region_in;
   cfg_type             cfg;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [BLOCK_W-1:0]  mem_wr_data;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [BLOCK_W-1:0]  mem_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      start_in  = start_ff;
      region_in = region_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOG_START:  start_in  = csr_data;
            CSR_LOG_REGION: region_in = csr_data[REGION_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= BLOCK_W'(2);
         region_ff <= REGION_W'(32);
      end else begin
         start_ff  <= start_in;
         region_ff <= region_in;
      end
   end

   assign cfg.log_start_block   = start_ff;
   assign cfg.log_region_blocks = region_ff;

   gclc_engine #(
      .LOG_ENTRIES (LOG_ENTRIES),
      .OP_RESERVE  (OP_RESERVE),
      .ADDR_W      (ADDR_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   gclc_log_mem #(
      .DEPTH  (LOG_ENTRIES),
      .ADDR_W (ADDR_W),
      .DATA_W (BLOCK_W)
   ) u_log_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
